FILE: design/tmbs_pkg.sv
// Shared types and constants for the tape machine bytecode step block.
package tmbs_pkg;

   localparam int CELL_ADDR_BITS = 16;
   localparam int TAPE_DEPTH     = 1 << CELL_ADDR_BITS;

   // decode queue between front and back (power-of-two depth)
   localparam int DQ_DEPTH    = 4;
   localparam int DQ_PTR_BITS = $clog2(DQ_DEPTH);
   localparam int DQ_CNT_BITS = $clog2(DQ_DEPTH + 1);

   // result queue in the back end
   localparam int RQ_DEPTH    = 2;
   localparam int RQ_PTR_BITS = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_BITS = $clog2(RQ_DEPTH + 1);

   // opcodes
   localparam logic [3:0] OP_HALT     = 4'd0;
   localparam logic [3:0] OP_NOP      = 4'd1;
   localparam logic [3:0] OP_OUT      = 4'd2;
   localparam logic [3:0] OP_IN       = 4'd3;
   localparam logic [3:0] OP_ADD      = 4'd4;
   localparam logic [3:0] OP_SUB      = 4'd5;
   localparam logic [3:0] OP_HEAD_UP  = 4'd6;
   localparam logic [3:0] OP_HEAD_DN  = 4'd7;
   localparam logic [3:0] OP_JZ       = 4'd8;
   localparam logic [3:0] OP_JNZ      = 4'd9;

   // pc advance per instruction length
   localparam logic [2:0] PC_STEP_NONE  = 3'd0;
   localparam logic [2:0] PC_STEP_SHORT = 3'd1;
   localparam logic [2:0] PC_STEP_CELL  = 3'd2;
   localparam logic [2:0] PC_STEP_LONG  = 3'd5;

   // tick costs
   localparam logic [2:0] TICK_NONE  = 3'd0;
   localparam logic [2:0] TICK_NOP   = 3'd1;
   localparam logic [2:0] TICK_IO    = 3'd4;
   localparam logic [2:0] TICK_HEAD  = 3'd6;
   localparam logic [2:0] TICK_JUMP  = 3'd6;
   localparam logic [2:0] TICK_TAKEN = 3'd7;

   typedef logic [CELL_ADDR_BITS-1:0] cell_addr_type;

   typedef enum logic [3:0] {
      K_HALT,
      K_NOP,
      K_OUT,
      K_IN,
      K_ADD,
      K_SUB,
      K_HEAD,
      K_JZ,
      K_JNZ,
      K_BAD
   } kind_type;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] operand;
      logic [7:0]         in_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        branch_taken;
      logic        halted;
      logic [2:0]  tick_cost;
   } rsp_item_type;

   typedef struct packed {
      kind_type      kind;
      logic [2:0]    pc_inc;
      logic [2:0]    tick_base;
      cell_addr_type addr;
      logic [31:0]   imm;
      logic [7:0]    in_byte;
   } dq_entry_type;

   typedef struct packed {
      logic         valid;
      dq_entry_type entry;
   } dq_link_type;

endpackage

FILE: design/tmbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tmbs_front.sv
// Front end: accepts instructions, decodes them, tracks the head pointer, queues work.
module tmbs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  hold,
   input  tmbs_pkg::req_item_type req_data,
   output tmbs_pkg::dq_link_type dq_head,
   input  logic                  dq_pop
);
   import tmbs_pkg::*;

   logic [31:0]            head_ff, head_in;
   dq_entry_type           dq_mem_ff [DQ_DEPTH];
   logic [DQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DQ_CNT_BITS-1:0] count_ff, count_in;
   logic                   accept;
   dq_entry_type           dec;

   assign full   = hold || (count_ff == DQ_CNT_BITS'(DQ_DEPTH));
   assign accept = push && !full;

   always_comb begin
      dec           = '0;
      dec.addr      = head_ff[CELL_ADDR_BITS-1:0];
      dec.imm       = $unsigned(req_data.operand);
      dec.in_byte   = req_data.in_byte;
      head_in       = head_ff;
      unique case (req_data.req_type)
         OP_HALT: begin
            dec.kind = K_HALT;  dec.pc_inc = PC_STEP_NONE;  dec.tick_base = TICK_NONE;
         end
         OP_NOP: begin
            dec.kind = K_NOP;   dec.pc_inc = PC_STEP_SHORT; dec.tick_base = TICK_NOP;
         end
         OP_OUT: begin
            dec.kind = K_OUT;   dec.pc_inc = PC_STEP_SHORT; dec.tick_base = TICK_IO;
         end
         OP_IN: begin
            dec.kind = K_IN;    dec.pc_inc = PC_STEP_SHORT; dec.tick_base = TICK_IO;
         end
         OP_ADD: begin
            dec.kind = K_ADD;   dec.pc_inc = PC_STEP_CELL;  dec.tick_base = TICK_IO;
         end
         OP_SUB: begin
            dec.kind = K_SUB;   dec.pc_inc = PC_STEP_CELL;  dec.tick_base = TICK_IO;
         end
         OP_HEAD_UP: begin
            dec.kind = K_HEAD;  dec.pc_inc = PC_STEP_LONG;  dec.tick_base = TICK_HEAD;
            head_in  = head_ff + $unsigned(req_data.operand);
         end
         OP_HEAD_DN: begin
            dec.kind = K_HEAD;  dec.pc_inc = PC_STEP_LONG;  dec.tick_base = TICK_HEAD;
            head_in  = head_ff - $unsigned(req_data.operand);
         end
         OP_JZ: begin
            dec.kind = K_JZ;    dec.pc_inc = PC_STEP_LONG;  dec.tick_base = TICK_JUMP;
         end
         OP_JNZ: begin
            dec.kind = K_JNZ;   dec.pc_inc = PC_STEP_LONG;  dec.tick_base = TICK_JUMP;
         end
         default: begin
            dec.kind = K_BAD;   dec.pc_inc = PC_STEP_NONE;  dec.tick_base = TICK_NONE;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (dq_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      priority if (accept && !dq_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && dq_pop) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            head_ff <= head_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dq_mem_ff[wr_ptr_ff] <= dec;
      end
   end

   assign dq_head.valid = (count_ff != '0);
   assign dq_head.entry = dq_mem_ff[rd_ptr_ff];

endmodule

FILE: design/tmbs_back.sv
// Back end: tape read-modify-write, program counter, result queue and tape clear sweep.
module tmbs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tmbs_pkg::dq_link_type dq_head,
   output logic                  dq_pop,
   output logic                  clearing,
   output tmbs_pkg::rsp_item_type rsp_data,
   output logic                  empty,
   input  logic                  pop
);
   import tmbs_pkg::*;

   // tape clear sweep
   logic          clr_busy_ff;
   cell_addr_type clr_addr_ff;

   // execute stage
   logic          exec_valid_ff, exec_valid_in;
   dq_entry_type  exec_ff;
   logic          exec_fire, load;
   logic [31:0]   pc_ff;

   // last tape write, forwarded over the registered read gap
   logic          lw_valid_ff;
   cell_addr_type lw_addr_ff;
   logic [7:0]    lw_data_ff;

   // tape port
   logic          wr_en;
   cell_addr_type wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   logic          cell_wr;
   logic [7:0]    cell_val, new_cell;
   rsp_item_type  res;

   // result queue
   rsp_item_type           rq_mem_ff [RQ_DEPTH];
   logic [RQ_PTR_BITS-1:0] rq_wr_ff, rq_rd_ff;
   logic [RQ_CNT_BITS-1:0] rq_cnt_ff;
   logic                   rq_full, rq_pop;

   assign clearing  = clr_busy_ff;
   assign rq_full   = (rq_cnt_ff == RQ_CNT_BITS'(RQ_DEPTH));
   assign exec_fire = exec_valid_ff && !rq_full;
   assign load      = dq_head.valid && !clr_busy_ff && (!exec_valid_ff || exec_fire);
   assign dq_pop    = load;
   assign rd_addr   = load ? dq_head.entry.addr : exec_ff.addr;

   always_comb begin
      priority if (load) begin
         exec_valid_in = 1'b1;
      end else if (exec_fire) begin
         exec_valid_in = 1'b0;
      end else begin
         exec_valid_in = exec_valid_ff;
      end
   end

   always_comb begin
      cell_val = (lw_valid_ff && (lw_addr_ff == exec_ff.addr)) ? lw_data_ff : rd_data;
      new_cell         = cell_val;
      cell_wr          = 1'b0;
      res              = '0;
      res.next_pc      = pc_ff + 32'(exec_ff.pc_inc);
      res.tick_cost    = exec_ff.tick_base;
      unique case (exec_ff.kind)
         K_HALT: res.halted = 1'b1;
         K_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = cell_val;
         end
         K_IN: begin
            cell_wr  = 1'b1;
            new_cell = exec_ff.in_byte;
         end
         K_ADD: begin
            cell_wr  = 1'b1;
            new_cell = cell_val + exec_ff.imm[7:0];
         end
         K_SUB: begin
            cell_wr  = 1'b1;
            new_cell = cell_val - exec_ff.imm[7:0];
         end
         K_JZ:    res.branch_taken = (cell_val == 8'd0);
         K_JNZ:   res.branch_taken = (cell_val != 8'd0);
         default: res.halted = 1'b0;
      endcase
      if (res.branch_taken) begin
         res.next_pc   = pc_ff + 32'(exec_ff.pc_inc) + exec_ff.imm;
         res.tick_cost = TICK_TAKEN;
      end
   end

   assign wr_en   = clr_busy_ff || (exec_fire && cell_wr);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : exec_ff.addr;
   assign wr_data = clr_busy_ff ? 8'd0 : new_cell;

   tmbs_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         exec_valid_ff <= 1'b0;
         pc_ff         <= '0;
         lw_valid_ff   <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               clr_busy_ff <= 1'b0;
            end
         end
         exec_valid_ff <= exec_valid_in;
         if (exec_fire) begin
            pc_ff <= res.next_pc;
         end
         if (wr_en) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         exec_ff <= dq_head.entry;
      end
      if (wr_en) begin
         lw_addr_ff <= wr_addr;
         lw_data_ff <= wr_data;
      end
   end

   // result queue
   assign empty  = (rq_cnt_ff == '0);
   assign rq_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         if (exec_fire) begin
            rq_wr_ff <= rq_wr_ff + 1'b1;
         end
         if (rq_pop) begin
            rq_rd_ff <= rq_rd_ff + 1'b1;
         end
         priority if (exec_fire && !rq_pop) begin
            rq_cnt_ff <= rq_cnt_ff + 1'b1;
         end else if (!exec_fire && rq_pop) begin
            rq_cnt_ff <= rq_cnt_ff - 1'b1;
         end else begin
            rq_cnt_ff <= rq_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rq_mem_ff[rq_wr_ff] <= res;
      end
   end

   assign rsp_data = rq_mem_ff[rq_rd_ff];

endmodule

FILE: design/tape_machine_bytecode_step.sv
// Tape machine bytecode step: front decode, decode queue, back tape execute.
// A pushed beat passes the decode queue and execute register into the result queue.
// Throughput: one instruction per cycle while the result queue has room; one tape RAM
//   read-modify-write per cycle, with last-write forwarding for back-to-back updates.
// Reset (synchronous, active high): pc and head go to zero, then a clear sweep writes
//   zero to all 65536 tape cells, one per cycle; full stays high during those cycles.
module tape_machine_bytecode_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  tmbs_pkg::req_item_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output tmbs_pkg::rsp_item_type rsp_data
);
   import tmbs_pkg::*;

   dq_link_type dq_head;
   logic        dq_pop;
   logic        clearing;

   // Front: decode, head pointer update and tape address are known at accept time,
   // so head moves never wait on the tape.
   tmbs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .hold     (clearing),
      .req_data (req_data),
      .dq_head  (dq_head),
      .dq_pop   (dq_pop)
   );

   // Back: reads the head cell, applies the cell op, resolves jumps against the pc,
   // and parks the result beat in a two-entry queue, absorbing stalls until it fills.
   tmbs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .dq_head  (dq_head),
      .dq_pop   (dq_pop),
      .clearing (clearing),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

FILE: tb/sv/tape_machine_bytecode_step_tb.sv
// Self-checking testbench for the tape machine bytecode step block.
`timescale 1ns / 1ps

module tape_machine_bytecode_step_tb;
   import tmbs_pkg::*;

   // Random part: beats with a defined opcode that count toward the run length.
   localparam int RANDOM_BEATS = 550;
   // The tail wait after the last result leaves a little margin before the
   // final check.
   localparam int TAIL_CYCLES = 8;

   // One row of the directed table. Where known is set, the expected result
   // is typed into the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic         known;
      req_item_type beat;
      rsp_item_type want;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         pop = 1'b0;
   req_item_type req_data = '0;
   logic         full;
   logic         empty;
   rsp_item_type rsp_data;

   // Machine state as the predictor sees it.
   logic [31:0] pc_copy;
   logic [31:0] head_copy;
   logic [7:0]  tape_copy [TAPE_DEPTH];

   rsp_item_type owed_results [$];
   plan_row_type plan_rows [$];
   req_item_type queued_beats [$];

   int bad_fields = 0;
   int results_seen = 0;

   // Runs of back-to-back beats on either side come from these two flags.
   bit send_steady = 1'b0;
   bit take_steady = 1'b0;

   tape_machine_bytecode_step i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Executes one instruction on the state copy and returns its result beat.
   function automatic rsp_item_type execute_instruction(input req_item_type beat);
      rsp_item_type  res;
      cell_addr_type at;
      logic [7:0]    cell_val;
      logic [31:0]   imm;
      res = '0;
      imm = beat.operand;
      // only the low address bits of the head pick a cell, so the tape wraps
      at = head_copy[CELL_ADDR_BITS-1:0];
      cell_val = tape_copy[at];
      res.next_pc = pc_copy;
      case (beat.req_type)
         OP_HALT: begin
            res.halted = 1'b1;
         end
         OP_NOP: begin
            res.next_pc = pc_copy + PC_STEP_SHORT;
            res.tick_cost = TICK_NOP;
         end
         OP_OUT: begin
            res.next_pc = pc_copy + PC_STEP_SHORT;
            res.out_valid = 1'b1;
            res.out_byte = cell_val;
            res.tick_cost = TICK_IO;
         end
         OP_IN: begin
            res.next_pc = pc_copy + PC_STEP_SHORT;
            tape_copy[at] = beat.in_byte;
            res.tick_cost = TICK_IO;
         end
         OP_ADD: begin
            res.next_pc = pc_copy + PC_STEP_CELL;
            tape_copy[at] = cell_val + imm[7:0];
            res.tick_cost = TICK_IO;
         end
         OP_SUB: begin
            res.next_pc = pc_copy + PC_STEP_CELL;
            tape_copy[at] = cell_val - imm[7:0];
            res.tick_cost = TICK_IO;
         end
         OP_HEAD_UP: begin
            res.next_pc = pc_copy + PC_STEP_LONG;
            head_copy = head_copy + imm;
            res.tick_cost = TICK_HEAD;
         end
         OP_HEAD_DN: begin
            res.next_pc = pc_copy + PC_STEP_LONG;
            head_copy = head_copy - imm;
            res.tick_cost = TICK_HEAD;
         end
         OP_JZ, OP_JNZ: begin
            res.next_pc = pc_copy + PC_STEP_LONG;
            res.tick_cost = TICK_JUMP;
            if ((beat.req_type == OP_JZ) == (cell_val == 8'h00)) begin
               res.next_pc = res.next_pc + imm;
               res.branch_taken = 1'b1;
               res.tick_cost = TICK_TAKEN;
            end
         end
         default: begin
            // undefined opcodes leave everything alone and report the unchanged pc, zeros elsewhere
         end
      endcase
      pc_copy = res.next_pc;
      return res;
   endfunction

   function automatic req_item_type make_beat(input logic [3:0] op, input logic [31:0] opnd,
                                              input logic [7:0] inb);
      req_item_type beat;
      beat.req_type = op;
      beat.operand = opnd;
      beat.in_byte = inb;
      return beat;
   endfunction

   task automatic plan_beat(input logic [3:0] op, input logic [31:0] opnd,
                            input logic [7:0] inb);
      plan_row_type row;
      row.known = 1'b0;
      row.beat = make_beat(op, opnd, inb);
      row.want = '0;
      plan_rows.push_back(row);
   endtask

   task automatic plan_known(input logic [3:0] op, input logic [31:0] opnd,
                             input logic [7:0] inb, input logic [31:0] pc,
                             input logic valid, input logic [7:0] obyte,
                             input logic taken, input logic halt, input logic [2:0] ticks);
      plan_row_type row;
      row.known = 1'b1;
      row.beat = make_beat(op, opnd, inb);
      row.want.next_pc = pc;
      row.want.out_valid = valid;
      row.want.out_byte = obyte;
      row.want.branch_taken = taken;
      row.want.halted = halt;
      row.want.tick_cost = ticks;
      plan_rows.push_back(row);
   endtask

   // Random instruction: mostly defined opcodes, a few undefined ones, head
   // moves kept short most of the time so that cells get revisited.
   function automatic req_item_type random_beat();
      req_item_type beat;
      beat.operand = $urandom;
      beat.in_byte = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      if ($urandom_range(0, 9) == 0)
         beat.req_type = 4'($urandom_range(0, 15));
      else
         beat.req_type = 4'($urandom_range(OP_HALT, OP_JNZ));
      if ((beat.req_type == OP_HEAD_UP || beat.req_type == OP_HEAD_DN) &&
          $urandom_range(0, 3) != 0)
         beat.operand = $urandom_range(0, 3);
      return beat;
   endfunction

   // Offers one beat after a random gap; predicts it at the accepting edge.
   task automatic send_beat(input req_item_type beat, input logic known,
                            input rsp_item_type want);
      int gap;
      rsp_item_type predicted;
      if ($urandom_range(0, 31) == 0)
         send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (full !== 1'b0);
      // state advances even for rows whose result is typed in
      predicted = execute_instruction(beat);
      owed_results.push_back(known ? want : predicted);
   endtask

   // Holds the sender off until every owed result has come back.
   task automatic wait_for_drain();
      push <= 1'b0;
      do @(posedge clock); while (owed_results.size() != 0);
   endtask

   task automatic flag_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
      bad_fields++;
      $display("ERROR result %0d field %s: got 0x%h, want 0x%h",
               results_seen, field, got, want);
   endtask

   task automatic compare_result(input rsp_item_type got, input rsp_item_type want);
      if (got.next_pc !== want.next_pc)
         flag_field("next_pc", got.next_pc, want.next_pc);
      if (got.out_valid !== want.out_valid)
         flag_field("out_valid", 32'(got.out_valid), 32'(want.out_valid));
      if (got.out_byte !== want.out_byte)
         flag_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      if (got.branch_taken !== want.branch_taken)
         flag_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
      if (got.halted !== want.halted)
         flag_field("halted", 32'(got.halted), 32'(want.halted));
      if (got.tick_cost !== want.tick_cost)
         flag_field("tick_cost", 32'(got.tick_cost), 32'(want.tick_cost));
   endtask

   // Result side: random stalls, each beat taken at an edge with pop high and
   // empty low, then checked against the oldest owed result.
   initial begin : take_results
      int stall;
      rsp_item_type got;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            take_steady = !take_steady;
         stall = take_steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty !== 1'b0);
         got = rsp_data;
         if (owed_results.size() == 0) begin
            bad_fields++;
            $display("ERROR result %0d arrived with nothing owed: next_pc 0x%h",
                     results_seen, got.next_pc);
         end else begin
            compare_result(got, owed_results.pop_front());
         end
         results_seen++;
      end
   end

   initial begin : run_program
      int counted;
      int k;
      bit paused;
      req_item_type beat;
      plan_row_type row;

      pc_copy = '0;
      head_copy = '0;
      for (int i = 0; i < TAPE_DEPTH; i++)
         tape_copy[i] = 8'h00;

      // Directed table. Typed rows follow a fresh tape, pc 0 and head 0.
      // halt right after reset, ignoring its operand
      plan_known(OP_HALT, 32'hFFFF_FFFF, 8'hFF, 32'h0, 1'b0, 8'h00, 1'b0, 1'b1, TICK_NONE);
      plan_known(OP_OUT, 32'h0, 8'h00, 32'h1, 1'b1, 8'h00, 1'b0, 1'b0, TICK_IO);
      // undefined opcode with every other bit set: no effect at all
      plan_known(4'hF, 32'hFFFF_FFFF, 8'hFF, 32'h1, 1'b0, 8'h00, 1'b0, 1'b0, TICK_NONE);
      plan_known(OP_IN, 32'h0, 8'hFF, 32'h2, 1'b0, 8'h00, 1'b0, 1'b0, TICK_IO);
      // cell wraps 0xff -> 0x00, then back-to-back jumps read the new value
      plan_known(OP_ADD, 32'h1, 8'h00, 32'h4, 1'b0, 8'h00, 1'b0, 1'b0, TICK_IO);
      plan_known(OP_JZ, 32'h7FFF_FFFF, 8'h00, 32'h8000_0008, 1'b0, 8'h00, 1'b1, 1'b0,
                 TICK_TAKEN);
      plan_known(OP_JNZ, 32'h8000_0000, 8'h00, 32'h8000_000D, 1'b0, 8'h00, 1'b0, 1'b0,
                 TICK_JUMP);
      // only the low operand byte takes part in cell arithmetic
      plan_known(OP_SUB, 32'hFFFF_FF01, 8'h00, 32'h8000_000F, 1'b0, 8'h00, 1'b0, 1'b0,
                 TICK_IO);
      plan_known(OP_OUT, 32'h0, 8'h00, 32'h8000_0010, 1'b1, 8'hFF, 1'b0, 1'b0, TICK_IO);
      // most negative offset wraps the pc past zero
      plan_known(OP_JNZ, 32'h8000_0000, 8'h00, 32'h0000_0015, 1'b0, 8'h00, 1'b1, 1'b0,
                 TICK_TAKEN);
      // head below zero lands on the top cell of the tape
      plan_known(OP_HEAD_DN, 32'h1, 8'h00, 32'h1A, 1'b0, 8'h00, 1'b0, 1'b0, TICK_HEAD);
      plan_known(OP_OUT, 32'h0, 8'h00, 32'h1B, 1'b1, 8'h00, 1'b0, 1'b0, TICK_IO);
      plan_known(OP_NOP, 32'h8000_0000, 8'hA5, 32'h1C, 1'b0, 8'h00, 1'b0, 1'b0, TICK_NOP);
      // head past the tape wraps onto cell zero again
      plan_beat(OP_HEAD_UP, 32'h0001_0001, 8'h00);
      plan_beat(OP_OUT, 32'h0, 8'h00);
      plan_beat(OP_JZ, 32'hFFFF_FFFA, 8'h00);
      plan_beat(OP_HEAD_UP, 32'h7FFF_FFFF, 8'h00);
      plan_beat(OP_IN, 32'h0, 8'hA5);
      plan_beat(OP_ADD, 32'hFFFF_FF80, 8'h00);
      plan_beat(OP_SUB, 32'h0000_00FF, 8'h00);
      plan_beat(OP_OUT, 32'h0, 8'h00);
      plan_beat(OP_HEAD_DN, 32'h8000_0000, 8'h00);
      plan_beat(OP_JZ, 32'h0, 8'h00);
      plan_beat(4'hA, 32'h1234_5678, 8'h5A);
      plan_beat(4'hC, 32'h8765_4321, 8'hC3);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full stays high through the tape clear sweep; send_beat waits it out
      foreach (plan_rows[i]) begin
         row = plan_rows[i];
         send_beat(row.beat, row.known, row.want);
      end
      wait_for_drain();

      counted = 0;
      paused = 1'b0;
      while (counted < RANDOM_BEATS) begin
         if (queued_beats.size() == 0) begin
            if ($urandom_range(0, 4) == 0) begin
               // countdown loop: load a small count, then sub/jnz until zero;
               // exercises back-to-back cell updates feeding the branch test
               k = $urandom_range(1, 6);
               queued_beats.push_back(make_beat(OP_IN, $urandom, 8'(k)));
               repeat (k) begin
                  queued_beats.push_back(make_beat(OP_SUB,
                                                   {24'($urandom_range(0, 16777215)),
                                                    8'h01}, 8'($urandom)));
                  if ($urandom_range(0, 2) == 0)
                     queued_beats.push_back(make_beat(OP_OUT, $urandom, 8'($urandom)));
                  queued_beats.push_back(make_beat(OP_JNZ, 32'hFFFF_FFF9, 8'($urandom)));
               end
            end else begin
               queued_beats.push_back(random_beat());
            end
         end
         beat = queued_beats.pop_front();
         send_beat(beat, 1'b0, '0);
         // undefined opcodes are ignored by the machine and do not count
         if (beat.req_type <= OP_JNZ)
            counted++;
         if (!paused && counted >= RANDOM_BEATS / 2) begin
            paused = 1'b1;
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_fields == 0 && owed_results.size() == 0) begin
         $display("tape_machine_bytecode_step: match");
      end else begin
         $display("tape_machine_bytecode_step: mismatch");
      end
      $finish;
   end

   // Watchdog: the clear sweep plus the slowest run is far below this.
   initial begin : watchdog
      #10_000_000;
      $display("ERROR run timed out with %0d results owed", owed_results.size());
      $display("tape_machine_bytecode_step: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
design/tmbs_pkg.sv
design/tmbs_ram.sv
design/tmbs_front.sv
design/tmbs_back.sv
design/tape_machine_bytecode_step.sv
tb/sv/tape_machine_bytecode_step_tb.sv
